[hw/rtl/stbf_pkg.sv]
// Shared types and constants for the stateful TCP/IPv6 bridge filter.
// Used by the cell row and the top level; depends on nothing.
package stbf_pkg;

  localparam int IDX_W = 12;

  localparam logic [15:0] ETH_IPV6     = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] MCAST_PREFIX = 16'h3333;

  localparam logic REG_BCAST_IPV4 = 1'b0;
  localparam logic REG_BCAST_PORT = 1'b1;

  typedef struct packed {
    logic [31:0] ports;
    logic [63:0] ip_hi;
    logic [63:0] ip_lo;
    logic [47:0] mac_key;
  } query_t;

  typedef struct packed {
    logic             conn_hit;
    logic             conn_free;
    logic [IDX_W-1:0] conn_free_idx;
    logic             blk_hit;
    logic             blk_free;
    logic [IDX_W-1:0] blk_free_idx;
    logic             mac_hit;
    logic [IDX_W-1:0] mac_idx;
    logic [47:0]      mac_peer;
    logic             mac_free;
    logic [IDX_W-1:0] mac_free_idx;
  } acc_t;

  typedef struct packed {
    logic             conn_we;
    logic [IDX_W-1:0] conn_idx;
    logic             blk_we;
    logic [IDX_W-1:0] blk_idx;
    logic             mac_we;
    logic             mac_key_we;
    logic [IDX_W-1:0] mac_idx;
    logic [47:0]      mac_peer;
  } wr_t;

endpackage

[hw/rtl/stateful_tcp_ipv6_bridge_filter_unit.sv]
// Stateful TCP/IPv6 bridge filter: top level with control and the cell row.
// Depends on stbf_pkg and stbf_cell.
// The search walks the whole cell row of N cells, N being the largest table depth.
// One request is worked at a time; the next is accepted once its result is issued.
// Reset clears all valid bits, the control state and the registers.
module stateful_tcp_ipv6_bridge_filter_unit #(
  parameter int CONN_ENTRIES  = 64,
  parameter int BLOCK_ENTRIES = 64,
  parameter int MAC_ENTRIES   = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode, ethertype, next_header, syn_flag, src_port, dst_port, remote_ip_hi,
  // remote_ip_lo, src_mac, dst_mac, peer_ipv4, peer_port
  input  logic [335:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // forward, unicast, dest_ipv4, dest_port, newly_blacklisted
  output logic [55:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int N_A = (CONN_ENTRIES > BLOCK_ENTRIES) ? CONN_ENTRIES : BLOCK_ENTRIES;
  localparam int N   = (N_A > MAC_ENTRIES) ? N_A : MAC_ENTRIES;

  logic [31:0] bcast_ipv4;
  logic [15:0] bcast_port;
  logic        busy;
  logic        go;
  logic        fin_valid;
  stbf_pkg::acc_t fin_acc;
  stbf_pkg::query_t q;
  logic        q_mode;
  logic        q_ipv6;
  logic        q_tcp;
  logic        q_syn;
  logic        q_learn_ok;
  logic [47:0] q_peer;
  stbf_pkg::wr_t wr;
  logic        finish;
  logic        accept;
  logic        fwd;
  logic        nb;
  logic        uni;
  logic [31:0] dip;
  logic [15:0] dp;

  logic           chain_v   [N+1];
  stbf_pkg::acc_t chain_acc [N+1];

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign finish   = fin_valid && (!m_tvalid || m_tready);

  assign chain_v[0]   = go;
  assign chain_acc[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    stbf_cell #(
      .IDX      (i),
      .HAS_CONN (i < CONN_ENTRIES),
      .HAS_BLOCK(i < BLOCK_ENTRIES),
      .HAS_MAC  (i < MAC_ENTRIES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .q        (q),
      .wr       (wr),
      .in_valid (chain_v[i]),
      .in_acc   (chain_acc[i]),
      .out_valid(chain_v[i+1]),
      .out_acc  (chain_acc[i+1])
    );
  end

  always_comb begin
    wr       = '0;
    fwd      = 1'b0;
    nb       = 1'b0;
    uni      = 1'b0;
    dip      = '0;
    dp       = '0;
    wr.conn_idx = fin_acc.conn_free_idx;
    wr.blk_idx  = fin_acc.blk_free_idx;
    wr.mac_idx  = fin_acc.mac_hit ? fin_acc.mac_idx : fin_acc.mac_free_idx;
    wr.mac_peer = q_peer;
    if (!q_mode) begin
      fwd = 1'b1;
      wr.conn_we = q_ipv6 && q_tcp && q_syn && !fin_acc.conn_hit && fin_acc.conn_free;
      uni = fin_acc.mac_hit;
      dip = fin_acc.mac_hit ? fin_acc.mac_peer[47:16] : bcast_ipv4;
      dp  = fin_acc.mac_hit ? fin_acc.mac_peer[15:0] : bcast_port;
    end else begin
      if (!fin_acc.blk_hit) begin
        if (!q_ipv6) begin
          fwd = 1'b1;
        end else if (q_tcp) begin
          if (fin_acc.conn_hit) begin
            fwd = 1'b1;
          end else if (fin_acc.blk_free) begin
            wr.blk_we = 1'b1;
            nb = 1'b1;
          end
        end
      end
      if (fwd && q_learn_ok) begin
        wr.mac_we     = fin_acc.mac_hit || fin_acc.mac_free;
        wr.mac_key_we = !fin_acc.mac_hit;
      end
    end
    wr.conn_we = wr.conn_we && finish;
    wr.blk_we  = wr.blk_we && finish;
    wr.mac_we  = wr.mac_we && finish;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode       <= s_tdata[0];
      q_ipv6       <= s_tdata[16:1] == stbf_pkg::ETH_IPV6;
      q_tcp        <= s_tdata[24:17] == stbf_pkg::PROTO_TCP;
      q_syn        <= s_tdata[25];
      q.ports      <= s_tdata[0] ? {s_tdata[57:42], s_tdata[41:26]}
                                 : {s_tdata[41:26], s_tdata[57:42]};
      q.ip_hi      <= s_tdata[121:58];
      q.ip_lo      <= s_tdata[185:122];
      q.mac_key    <= s_tdata[0] ? s_tdata[233:186] : s_tdata[281:234];
      q_learn_ok   <= s_tdata[281:234] != stbf_pkg::MAC_BCAST
                      && s_tdata[281:266] != stbf_pkg::MCAST_PREFIX;
      q_peer       <= {s_tdata[313:282], s_tdata[329:314]};
    end
    if (chain_v[N]) begin
      fin_acc <= chain_acc[N];
    end
    if (finish) begin
      m_tdata <= {5'd0, nb, dp, dip, uni, fwd};
    end
    if (rst) begin
      busy       <= 1'b0;
      go         <= 1'b0;
      fin_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
      bcast_ipv4 <= '0;
      bcast_port <= '0;
    end else begin
      go <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (chain_v[N]) begin
        fin_valid <= 1'b1;
      end else if (finish) begin
        fin_valid <= 1'b0;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          stbf_pkg::REG_BCAST_IPV4: bcast_ipv4 <= cfg_wdata;
          stbf_pkg::REG_BCAST_PORT: bcast_port <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    chain_v[N] |-> busy && !fin_valid)
    else $error("search result arrived without a pending request");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !fin_valid)
    else $error("request accepted while the previous one was still open");

  a_drop_on_blacklist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[50] && m_tdata[0]))
    else $error("blacklisting request was forwarded");

endmodule

[hw/rtl/stbf_cell.sv]
// One cell of the table row: at most one connection, blacklist and MAC entry each.
// Compares its entries with the broadcast query and passes the search record on.
module stbf_cell #(
  parameter int IDX       = 0,
  parameter bit HAS_CONN  = 1'b1,
  parameter bit HAS_BLOCK = 1'b1,
  parameter bit HAS_MAC   = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  stbf_pkg::query_t q,
  input  stbf_pkg::wr_t    wr,
  input  logic            in_valid,
  input  stbf_pkg::acc_t   in_acc,
  output logic            out_valid,
  output stbf_pkg::acc_t   out_acc
);

  localparam logic [stbf_pkg::IDX_W-1:0] MY_IDX = IDX[stbf_pkg::IDX_W-1:0];

  logic        c_valid;
  logic [31:0] c_ports;
  logic [63:0] c_hi;
  logic [63:0] c_lo;
  logic        b_valid;
  logic [63:0] b_hi;
  logic [63:0] b_lo;
  logic        m_valid;
  logic [47:0] m_key;
  logic [47:0] m_peer;
  stbf_pkg::acc_t acc_next;
  logic c_match;
  logic b_match;
  logic m_match;

  assign c_match = HAS_CONN && c_valid && c_ports == q.ports && c_hi == q.ip_hi
                   && c_lo == q.ip_lo;
  assign b_match = HAS_BLOCK && b_valid && b_hi == q.ip_hi && b_lo == q.ip_lo;
  assign m_match = HAS_MAC && m_valid && m_key == q.mac_key;

  always_comb begin
    acc_next = in_acc;
    acc_next.conn_hit = in_acc.conn_hit | c_match;
    acc_next.blk_hit  = in_acc.blk_hit | b_match;
    if (HAS_CONN && !c_valid && !in_acc.conn_free) begin
      acc_next.conn_free     = 1'b1;
      acc_next.conn_free_idx = MY_IDX;
    end
    if (HAS_BLOCK && !b_valid && !in_acc.blk_free) begin
      acc_next.blk_free     = 1'b1;
      acc_next.blk_free_idx = MY_IDX;
    end
    if (m_match && !in_acc.mac_hit) begin
      acc_next.mac_hit  = 1'b1;
      acc_next.mac_idx  = MY_IDX;
      acc_next.mac_peer = m_peer;
    end
    if (HAS_MAC && !m_valid && !in_acc.mac_free) begin
      acc_next.mac_free     = 1'b1;
      acc_next.mac_free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    out_acc <= acc_next;
    if (rst) begin
      out_valid <= 1'b0;
      c_valid   <= 1'b0;
      b_valid   <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (HAS_CONN && wr.conn_we && wr.conn_idx == MY_IDX) begin
        c_valid <= 1'b1;
      end
      if (HAS_BLOCK && wr.blk_we && wr.blk_idx == MY_IDX) begin
        b_valid <= 1'b1;
      end
      if (HAS_MAC && wr.mac_we && wr.mac_key_we && wr.mac_idx == MY_IDX) begin
        m_valid <= 1'b1;
      end
    end
    if (wr.conn_we && wr.conn_idx == MY_IDX) begin
      c_ports <= q.ports;
      c_hi    <= q.ip_hi;
      c_lo    <= q.ip_lo;
    end
    if (wr.blk_we && wr.blk_idx == MY_IDX) begin
      b_hi <= q.ip_hi;
      b_lo <= q.ip_lo;
    end
    if (wr.mac_we && wr.mac_idx == MY_IDX) begin
      m_peer <= wr.mac_peer;
      if (wr.mac_key_we) begin
        m_key <= q.mac_key;
      end
    end
  end

endmodule

[sim/stbf_checker.sv]
`timescale 1ns / 100ps
// Checker for the stateful TCP/IPv6 bridge filter: watches the request, result
// and register ports, predicts every verdict and compares it field by field.
module stbf_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [335:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [55:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata,
  output int           outstanding,
  output int           fail_count
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic        newly_blacklisted;
    logic [15:0] dest_port;
    logic [31:0] dest_ipv4;
    logic        unicast;
    logic        forward;
  } verdict_t;

  logic [31:0] bcast_ipv4_q;
  logic [15:0] bcast_port_q;

  logic        conn_v [DEPTH];
  logic [31:0] conn_p [DEPTH];
  logic [63:0] conn_h [DEPTH];
  logic [63:0] conn_l [DEPTH];
  logic        blk_v  [DEPTH];
  logic [63:0] blk_h  [DEPTH];
  logic [63:0] blk_l  [DEPTH];
  logic        mac_v  [DEPTH];
  logic [47:0] mac_k  [DEPTH];
  logic [47:0] mac_p  [DEPTH];

  verdict_t expected_verdicts[$];

  function automatic bit conn_known(logic [31:0] p, logic [63:0] h, logic [63:0] l);
    for (int i = 0; i < DEPTH; i++)
      if (conn_v[i] && conn_p[i] == p && conn_h[i] == h && conn_l[i] == l) return 1'b1;
    return 1'b0;
  endfunction

  function automatic verdict_t filter_frame(logic [335:0] d);
    logic        mode, syn;
    logic [15:0] etype, sport, dport, pport;
    logic [7:0]  nh;
    logic [63:0] hi, lo;
    logic [47:0] smac, dmac;
    logic [31:0] pip;
    verdict_t    v;
    bit          blocked, done;
    int          m;
    mode = d[0]; etype = d[16:1]; nh = d[24:17]; syn = d[25];
    sport = d[41:26]; dport = d[57:42]; hi = d[121:58]; lo = d[185:122];
    smac = d[233:186]; dmac = d[281:234]; pip = d[313:282]; pport = d[329:314];
    v = '0;
    if (!mode) begin
      if (etype == stbf_pkg::ETH_IPV6 && nh == stbf_pkg::PROTO_TCP && syn &&
          !conn_known({sport, dport}, hi, lo)) begin
        done = 1'b0;
        for (int i = 0; i < DEPTH && !done; i++)
          if (!conn_v[i]) begin
            conn_v[i] = 1'b1; conn_p[i] = {sport, dport}; conn_h[i] = hi; conn_l[i] = lo;
            done = 1'b1;
          end
      end
      v.forward = 1'b1;
      v.dest_ipv4 = bcast_ipv4_q;
      v.dest_port = bcast_port_q;
      for (int i = 0; i < DEPTH; i++)
        if (mac_v[i] && mac_k[i] == dmac) begin
          v.unicast = 1'b1; v.dest_ipv4 = mac_p[i][47:16]; v.dest_port = mac_p[i][15:0];
          break;
        end
    end else begin
      blocked = 1'b0;
      for (int i = 0; i < DEPTH; i++)
        if (blk_v[i] && blk_h[i] == hi && blk_l[i] == lo) blocked = 1'b1;
      if (!blocked) begin
        if (etype != stbf_pkg::ETH_IPV6) v.forward = 1'b1;
        else if (nh == stbf_pkg::PROTO_TCP) begin
          if (conn_known({dport, sport}, hi, lo)) v.forward = 1'b1;
          else begin
            done = 1'b0;
            for (int i = 0; i < DEPTH && !done; i++)
              if (!blk_v[i]) begin
                blk_v[i] = 1'b1; blk_h[i] = hi; blk_l[i] = lo; done = 1'b1;
              end
            v.newly_blacklisted = done;
          end
        end
      end
      if (v.forward && dmac != stbf_pkg::MAC_BCAST &&
          dmac[47:32] != stbf_pkg::MCAST_PREFIX) begin
        m = -1;
        for (int i = 0; i < DEPTH; i++)
          if (mac_v[i] && mac_k[i] == smac) begin m = i; break; end
        if (m < 0)
          for (int i = 0; i < DEPTH; i++)
            if (!mac_v[i]) begin m = i; mac_v[i] = 1'b1; mac_k[i] = smac; break; end
        if (m >= 0) mac_p[m] = {pip, pport};
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, exp_v;
    if (rst) begin
      bcast_ipv4_q <= '0;
      bcast_port_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        conn_v[i] = 1'b0; blk_v[i] = 1'b0; mac_v[i] = 1'b0;
      end
      expected_verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == stbf_pkg::REG_BCAST_IPV4) bcast_ipv4_q <= cfg_wdata;
        else bcast_port_q <= cfg_wdata[15:0];
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[50:0];
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result with no request pending: %h", got);
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (got.forward != exp_v.forward || got.unicast != exp_v.unicast ||
              got.dest_ipv4 != exp_v.dest_ipv4 || got.dest_port != exp_v.dest_port ||
              got.newly_blacklisted != exp_v.newly_blacklisted) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected fwd=%b uni=%b ip=%h port=%h nb=%b, ",
                        "got fwd=%b uni=%b ip=%h port=%h nb=%b"},
                       exp_v.forward, exp_v.unicast, exp_v.dest_ipv4, exp_v.dest_port,
                       exp_v.newly_blacklisted, got.forward, got.unicast, got.dest_ipv4,
                       got.dest_port, got.newly_blacklisted);
          end
        end
      end
      if (s_tvalid && s_tready) expected_verdicts.push_back(filter_frame(s_tdata));
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

[sim/tb_stateful_tcp_ipv6_bridge_filter_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the stateful TCP/IPv6 bridge filter: drives frame headers and
// register writes, paces the result side and reports the verdict of stbf_checker.
module tb_stateful_tcp_ipv6_bridge_filter_unit;

  localparam int IDLE_LIMIT = 20000;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [335:0] s_tdata;
  logic [55:0]  m_tdata;
  logic         cfg_we, cfg_index;
  logic [31:0]  cfg_wdata;
  int           outstanding, fail_count;
  int           accepted_requests;
  bit           hold_off_done;

  logic [63:0] ip_hi_pool [8];
  logic [63:0] ip_lo_pool [8];
  logic [47:0] mac_pool [8];
  logic [15:0] port_pool [4];
  logic [159:0] open_conns[$];

  stateful_tcp_ipv6_bridge_filter_unit u_top (.*);

  stbf_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [335:0] frame(logic mode, logic [15:0] et, logic [7:0] nh,
      logic syn, logic [15:0] sp, logic [15:0] dp, logic [63:0] hi, logic [63:0] lo,
      logic [47:0] sm, logic [47:0] dm, logic [31:0] pip, logic [15:0] pp);
    return {6'b0, pp, pip, dm, sm, lo, hi, dp, sp, syn, nh, et, mode};
  endfunction

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [335:0] random_frame();
    int          pick, k;
    logic [159:0] c;
    logic [15:0] et, sp, dp;
    logic [7:0]  nh;
    logic [47:0] dm;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    et = ($urandom_range(0, 3) == 0) ? 16'($urandom) : stbf_pkg::ETH_IPV6;
    nh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : stbf_pkg::PROTO_TCP;
    case ($urandom_range(0, 5))
      0: dm = stbf_pkg::MAC_BCAST;
      1: dm = {stbf_pkg::MCAST_PREFIX, 32'($urandom)};
      2: dm = {$urandom, 16'($urandom)};
      default: dm = mac_pool[$urandom_range(0, 7)];
    endcase
    sp = ($urandom_range(0, 1)) ? port_pool[$urandom_range(0, 3)] : 16'($urandom);
    dp = ($urandom_range(0, 1)) ? port_pool[$urandom_range(0, 3)] : 16'($urandom);
    if (pick < 35) begin
      c = {sp, dp, ip_hi_pool[k], ip_lo_pool[k]};
      if ($urandom_range(0, 7) == 0) c[127:0] = {r64(), r64()};
      open_conns.push_back(c);
      if (open_conns.size() > 32) void'(open_conns.pop_front());
      return frame(1'b0, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b1, c[159:144],
                   c[143:128], c[127:64], c[63:0], mac_pool[k], dm, $urandom,
                   16'($urandom));
    end else if (pick < 65 && open_conns.size() > 0) begin
      c = open_conns[$urandom_range(0, open_conns.size() - 1)];
      return frame(1'b1, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'($urandom),
                   c[143:128], c[159:144], c[127:64], c[63:0],
                   mac_pool[$urandom_range(0, 7)], dm, $urandom, 16'($urandom));
    end else if (pick < 80) begin
      return frame(1'($urandom), et, nh, 1'($urandom), sp, dp, ip_hi_pool[k],
                   ip_lo_pool[k], mac_pool[k], dm, $urandom, 16'($urandom));
    end
    return frame(1'($urandom), et, nh, 1'($urandom), sp, dp, r64(), r64(),
                 {$urandom, 16'($urandom)}, dm, $urandom, 16'($urandom));
  endfunction

  task automatic send(logic [335:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  always @(posedge clk)
    if (!rst && s_tvalid && s_tready) accepted_requests++;

  initial begin
    int stall_mode;
    m_tready = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (!hold_off_done && accepted_requests > 150) begin
        hold_off_done = 1;
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("** stateful_tcp_ipv6_bridge_filter_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] a_hi, a_lo, b_hi, b_lo;
    logic [47:0] m1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = stbf_pkg::REG_BCAST_IPV4;
    cfg_wdata = '0;
    for (int i = 0; i < 8; i++) begin
      ip_hi_pool[i] = r64();
      ip_lo_pool[i] = r64();
      mac_pool[i] = {$urandom, 16'($urandom)};
    end
    ip_hi_pool[0] = '0; ip_lo_pool[0] = '0;
    ip_hi_pool[1] = '1; ip_lo_pool[1] = '1;
    for (int i = 0; i < 4; i++) port_pool[i] = 16'($urandom);
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    a_hi = r64(); a_lo = r64(); b_hi = r64(); b_lo = r64();
    m1 = 48'h02_11_22_33_44_55;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(frame(1'b0, 16'h0800, 8'd6, 1'b1, 16'd1, 16'd2, a_hi, a_lo, m1, m1, 32'd0, 16'd0));
    settle();
    write_reg(stbf_pkg::REG_BCAST_IPV4, 32'hFFFF_FFFF);
    write_reg(stbf_pkg::REG_BCAST_PORT, 32'h0000_FFFF);
    send(frame(1'b0, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b1, 16'd1000, 16'd80,
               a_hi, a_lo, m1, m1, 32'd0, 16'd0));
    send(frame(1'b0, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b1, 16'd1000, 16'd80,
               a_hi, a_lo, m1, m1, 32'd0, 16'd0));
    send(frame(1'b1, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b0, 16'd80, 16'd1000,
               a_hi, a_lo, m1, 48'h02_00_00_00_00_01, 32'hC0A8_0001, 16'd4789));
    send(frame(1'b0, 16'h0800, 8'd17, 1'b0, 16'd5, 16'd6, b_hi, b_lo, 48'h0, m1,
               32'd0, 16'd0));
    send(frame(1'b1, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b1, 16'd22, 16'd23,
               b_hi, b_lo, m1, m1, 32'd1, 16'd1));
    send(frame(1'b1, 16'h0800, 8'd0, 1'b0, 16'd0, 16'd0, b_hi, b_lo, m1, m1,
               32'd1, 16'd1));
    send(frame(1'b1, 16'h0800, 8'd0, 1'b0, 16'd0, 16'd0, a_hi, ~a_lo, m1, m1,
               32'h0A00_0001, 16'd9));
    send(frame(1'b1, stbf_pkg::ETH_IPV6, 8'd17, 1'b0, 16'd0, 16'd0, a_hi, ~a_lo, m1, m1,
               32'd0, 16'd0));
    send(frame(1'b1, 16'h0800, 8'd0, 1'b0, 16'd0, 16'd0, '0, '0, m1, stbf_pkg::MAC_BCAST,
               32'd5, 16'd5));
    send(frame(1'b1, 16'h0800, 8'd0, 1'b0, 16'd0, 16'd0, '0, '1, m1,
               {stbf_pkg::MCAST_PREFIX, 32'h1}, 32'd6, 16'd6));
    send(frame(1'b0, stbf_pkg::ETH_IPV6, 8'd17, 1'b0, 16'd0, 16'd0, '0, '0, '0, m1,
               32'd0, 16'd0));
    send(frame(1'b1, 16'hFFFF, 8'hFF, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1));
    send(frame(1'b0, 16'hFFFF, 8'hFF, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1));
    send(frame(1'b1, 16'h0000, 8'h00, 1'b0, '0, '0, 64'h1, '0, '0, '0, '0, '0));
    send(frame(1'b0, 16'h0000, 8'h00, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send(frame(1'b0, stbf_pkg::ETH_IPV6, stbf_pkg::PROTO_TCP, 1'b0, '1, '0, a_hi, a_lo,
               '1, '1, '0, '0));
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(stbf_pkg::REG_BCAST_IPV4, '0);
          write_reg(stbf_pkg::REG_BCAST_PORT, '0);
        end
        1: begin
          write_reg(stbf_pkg::REG_BCAST_IPV4, '1);
          write_reg(stbf_pkg::REG_BCAST_PORT, 32'hFFFF);
        end
        default: begin
          write_reg(stbf_pkg::REG_BCAST_IPV4, $urandom);
          write_reg(stbf_pkg::REG_BCAST_PORT, 32'($urandom_range(0, 65535)));
        end
      endcase
      for (int n = 0; n < 125; n++) send(random_frame());
      settle();
    end

    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("** stateful_tcp_ipv6_bridge_filter_unit: PASSED **");
    end else begin
      $display("** stateful_tcp_ipv6_bridge_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule
